FILE: src/pgs_pkg.sv
// shared types and constants for the pressure gradient scale update block
`timescale 1ns / 1ps
package pgs_pkg;

   localparam int DATA_WIDTH_DEF  = 32;
   localparam int COUNT_WIDTH_DEF = 32;
   localparam int FIELD_W         = 32;
   localparam int FAC_W           = 17;
   localparam int CSR_ADDR_W      = 3;
   localparam int MUL_B_W         = 34;

   localparam logic [63:0] ONE_Q      = 64'd65536;
   localparam logic [63:0] AMAX_DEF   = 64'd6553600;
   localparam logic [63:0] FAC_DEF    = 64'd3277;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ALPHA_INIT    = 3'd0,
      CSR_DOMAIN_LENGTH = 3'd1,
      CSR_MAX_ALPHA     = 3'd2,
      CSR_PRESSURE_FAC  = 3'd3,
      CSR_MAX_MACH      = 3'd4,
      CSR_MAX_CHANGE    = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic [FIELD_W-1:0] domain_length;
      logic [FIELD_W-1:0] max_alpha;
      logic [FAC_W-1:0]   pressure_fac;
      logic [FIELD_W-1:0] max_mach;
      logic [FIELD_W-1:0] max_change;
   } cfg_type;

   typedef struct packed {
      logic               finish;
      logic               mach_zero;
      logic [FIELD_W-1:0] pressure;
      logic [FIELD_W-1:0] sound_speed;
      logic [FIELD_W-1:0] mach_number;
      logic [FIELD_W-1:0] time_step;
   } item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BOUND,
      ST_MEAN,
      ST_RMUL,
      ST_RDIV,
      ST_SQRT,
      ST_TMUL,
      ST_TDIV,
      ST_AMUL,
      ST_GMUL
   } state_type;

endpackage

FILE: src/pgs_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module pgs_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic        busy,
   output logic [63:0] quo
);
   logic [64:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [64:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[63:0], quo_ff[63]};
      if (start && !busy_ff) begin
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;
endmodule

FILE: src/pgs_front.sv
// request intake: saturation, classification and a two-entry queue
`timescale 1ns / 1ps
module pgs_front #(
   parameter int DATA_WIDTH = pgs_pkg::DATA_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [127:0]       req_tdata,  // pressure, sound_speed, mach_number, time_step
   input  logic               req_tuser,  // op
   output logic               q_valid,
   output pgs_pkg::item_type  q_item,
   input  logic               q_pop
);
   import pgs_pkg::*;

   localparam logic [63:0] DMAX = (64'd1 << DATA_WIDTH) - 64'd1;

   item_type    mem_ff [2];
   logic        wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push;
   item_type    item;

   function automatic logic [FIELD_W-1:0] sat_in(input logic [FIELD_W-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      return (w > DMAX) ? DMAX[FIELD_W-1:0] : v;
   endfunction

   always_comb begin
      item.finish      = req_tuser;
      item.pressure    = sat_in(req_tdata[31:0]);
      item.sound_speed = sat_in(req_tdata[63:32]);
      item.mach_number = sat_in(req_tdata[95:64]);
      item.time_step   = sat_in(req_tdata[127:96]);
      item.mach_zero   = (req_tdata[95:64] == '0);
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (cnt_ff != 2'd0);
   assign q_item     = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = (q_pop && q_valid) ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= item;
      end
   end
endmodule

FILE: src/pgs_back.sv
// accumulators, alpha update sequencer and result register
`timescale 1ns / 1ps
module pgs_back #(
   parameter int DATA_WIDTH  = pgs_pkg::DATA_WIDTH_DEF,
   parameter int COUNT_WIDTH = pgs_pkg::COUNT_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  pgs_pkg::item_type            q_item,
   output logic                         q_pop,
   input  pgs_pkg::cfg_type             cfg,
   input  logic                         alpha_load,
   input  logic [pgs_pkg::FIELD_W-1:0]  alpha_init,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [95:0]                  rsp_tdata,
   output logic                         rsp_tuser
);
   import pgs_pkg::*;

   localparam logic [63:0] DMAX = (64'd1 << DATA_WIDTH) - 64'd1;
   localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

   state_type state_ff, state_in;
   logic      launched_ff, launched_in;

   logic [63:0]            sum_ff, sum_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0]  plow_ff, plow_in, phigh_ff, phigh_in;
   logic [DATA_WIDTH-1:0]  chigh_ff, chigh_in, mhigh_ff, mhigh_in;
   logic [DATA_WIDTH-1:0]  bound_ff, bound_in, alpha_ff, alpha_in;

   logic [63:0] pmean_ff, pmean_in, ratio_ff, ratio_in;
   logic [63:0] root_ff, root_in, term_ff, term_in;

   logic [63:0]        mul_a_ff, mul_a_in;
   logic [MUL_B_W-1:0] mul_b_ff, mul_b_in;
   logic [97:0]        mul_acc_ff, mul_acc_in;
   logic [5:0]         mul_cnt_ff, mul_cnt_in;
   logic               mul_run_ff, mul_run_in;

   logic [63:0] sq_v_ff, sq_v_in, sq_res_ff, sq_res_in, sq_bit_ff, sq_bit_in;
   logic        sq_run_ff, sq_run_in;

   logic        rsp_valid_ff, rsp_valid_in, rsp_empty_ff, rsp_empty_in;
   logic [31:0] rsp_alpha_ff, rsp_alpha_in, rsp_mach_ff, rsp_mach_in;
   logic [31:0] rsp_mean_ff, rsp_mean_in;

   logic        div_start, div_busy;
   logic [63:0] div_num, div_den, div_q;

   logic        unit_idle, clear;
   logic [63:0] mul_res, d1, d2, dev, fac, amax, old, a, grow, step, sq_sum;
   logic [64:0] a_sum, sum_add;
   logic [63:0] p64, c64, m64, mh64, al64, ch64, b64;
   logic [DATA_WIDTH-1:0] p_d, c_d, m_d, qsat;

   function automatic logic [DATA_WIDTH-1:0] sat_d(input logic [63:0] v);
      return (v > DMAX) ? DMAX[DATA_WIDTH-1:0] : v[DATA_WIDTH-1:0];
   endfunction

   pgs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quo   (div_q)
   );

   assign unit_idle = !mul_run_ff && !sq_run_ff && !div_busy;
   assign mul_res   = (mul_acc_ff[97:64] != '0) ? '1 : mul_acc_ff[63:0];
   assign qsat      = sat_d(div_q);

   always_comb begin
      p64  = 64'(q_item.pressure);
      c64  = 64'(q_item.sound_speed);
      m64  = 64'(q_item.mach_number);
      p_d  = sat_d(p64);
      c_d  = sat_d(c64);
      m_d  = sat_d(m64);
      mh64 = 64'(mhigh_ff);
      al64 = 64'(alpha_ff);
      ch64 = 64'(chigh_ff);
      old  = al64;
      d1   = (64'(phigh_ff) > pmean_ff) ? 64'(phigh_ff) - pmean_ff : pmean_ff - 64'(phigh_ff);
      d2   = (64'(plow_ff) > pmean_ff) ? 64'(plow_ff) - pmean_ff : pmean_ff - 64'(plow_ff);
      dev  = (d1 > d2) ? d1 : d2;
      fac  = (cfg.pressure_fac == '0) ? FAC_DEF : 64'(cfg.pressure_fac);
      if (fac > ONE_Q) begin
         fac = ONE_Q;
      end
      amax = (cfg.max_alpha == '0) ? AMAX_DEF : 64'(cfg.max_alpha);
      step = (root_ff >= ONE_Q) ? root_ff - ONE_Q : ONE_Q - root_ff;
      sum_add = {1'b0, sum_ff} + 65'(p64);
      b64  = 64'(qsat);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && !q_item.finish && !q_item.mach_zero) begin
               state_in = ST_BOUND;
            end else if (q_valid && q_item.finish && !rsp_valid_ff && cnt_ff != '0) begin
               state_in = ST_MEAN;
            end
         end
         ST_BOUND: if (unit_idle) state_in = ST_IDLE;
         ST_MEAN:  if (unit_idle) state_in = ST_RMUL;
         ST_RMUL:  if (launched_ff && unit_idle) state_in = ST_RDIV;
         ST_RDIV: begin
            if (!launched_ff && dev == '0) begin
               state_in = ST_SQRT;
            end else if (launched_ff && unit_idle) begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT:  if (launched_ff && unit_idle) state_in = ST_TMUL;
         ST_TMUL:  if (launched_ff && unit_idle) state_in = ST_TDIV;
         ST_TDIV: begin
            if (!launched_ff && cfg.domain_length == '0) begin
               state_in = ST_AMUL;
            end else if (launched_ff && unit_idle) begin
               state_in = ST_AMUL;
            end
         end
         ST_AMUL:  if (launched_ff && unit_idle) state_in = ST_GMUL;
         ST_GMUL:  if (launched_ff && unit_idle) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and unit control
   always_comb begin
      launched_in = launched_ff;
      sum_in = sum_ff;   cnt_in = cnt_ff;
      plow_in = plow_ff; phigh_in = phigh_ff;
      chigh_in = chigh_ff; mhigh_in = mhigh_ff;
      bound_in = bound_ff; alpha_in = alpha_ff;
      pmean_in = pmean_ff; ratio_in = ratio_ff;
      root_in = root_ff;   term_in = term_ff;
      div_start = 1'b0; div_num = '0; div_den = '0;
      q_pop = 1'b0; clear = 1'b0;
      a = '0; grow = '0; a_sum = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_alpha_in = rsp_alpha_ff; rsp_mach_in = rsp_mach_ff;
      rsp_mean_in = rsp_mean_ff;   rsp_empty_in = rsp_empty_ff;

      // serial multiplier, msb of b first
      mul_a_in = mul_a_ff; mul_b_in = mul_b_ff; mul_acc_in = mul_acc_ff;
      mul_cnt_in = mul_cnt_ff; mul_run_in = mul_run_ff;
      if (mul_run_ff) begin
         mul_acc_in = {mul_acc_ff[96:0], 1'b0} + (mul_b_ff[MUL_B_W-1] ? 98'(mul_a_ff) : 98'd0);
         mul_b_in   = {mul_b_ff[MUL_B_W-2:0], 1'b0};
         mul_cnt_in = mul_cnt_ff - 6'd1;
         if (mul_cnt_ff == 6'd1) mul_run_in = 1'b0;
      end

      // bitwise square root, two bits of the radicand a step
      sq_v_in = sq_v_ff; sq_res_in = sq_res_ff; sq_bit_in = sq_bit_ff; sq_run_in = sq_run_ff;
      sq_sum = sq_res_ff + sq_bit_ff;
      if (sq_run_ff) begin
         if (sq_v_ff >= sq_sum) begin
            sq_v_in   = sq_v_ff - sq_sum;
            sq_res_in = (sq_res_ff >> 1) + sq_bit_ff;
         end else begin
            sq_res_in = sq_res_ff >> 1;
         end
         sq_bit_in = sq_bit_ff >> 2;
         if (sq_bit_ff[1:0] != 2'd0) sq_run_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && !q_item.finish) begin
               q_pop = 1'b1;
               if (cnt_ff != CMAX) begin
                  cnt_in = cnt_ff + COUNT_WIDTH'(1);
                  sum_in = sum_add[64] ? '1 : sum_add[63:0];
               end
               if (p_d < plow_ff)  plow_in  = p_d;
               if (p_d > phigh_ff) phigh_in = p_d;
               if (c_d > chigh_ff) chigh_in = c_d;
               if (m_d > mhigh_ff) mhigh_in = m_d;
               if (!q_item.mach_zero) begin
                  div_start = 1'b1;
                  div_num   = 64'(cfg.max_mach) << 16;
                  div_den   = m64;
               end
            end else if (q_valid && q_item.finish && !rsp_valid_ff) begin
               if (cnt_ff == '0) begin
                  q_pop = 1'b1; clear = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_alpha_in = al64[31:0];
                  rsp_mach_in  = mh64[31:0];
                  rsp_mean_in  = '0;
                  rsp_empty_in = 1'b1;
               end else begin
                  div_start = 1'b1;
                  div_num   = sum_ff;
                  div_den   = 64'(cnt_ff);
               end
            end
         end
         ST_BOUND: begin
            if (unit_idle && qsat < bound_ff) bound_in = qsat;
         end
         ST_MEAN: begin
            if (unit_idle) pmean_in = div_q;
         end
         ST_RMUL: begin
            if (!launched_ff) begin
               launched_in = 1'b1;
               mul_a_in = 64'(pmean_ff[31:0]); mul_b_in = MUL_B_W'(fac);
               mul_acc_in = '0; mul_cnt_in = 6'(MUL_B_W); mul_run_in = 1'b1;
            end else if (unit_idle) begin
               launched_in = 1'b0; ratio_in = mul_res;
            end
         end
         ST_RDIV: begin
            if (!launched_ff) begin
               if (dev == '0) begin
                  ratio_in = DMAX;
               end else begin
                  launched_in = 1'b1; div_start = 1'b1;
                  div_num = ratio_ff; div_den = dev;
               end
            end else if (unit_idle) begin
               launched_in = 1'b0; ratio_in = b64;
            end
         end
         ST_SQRT: begin
            if (!launched_ff) begin
               launched_in = 1'b1;
               sq_v_in = ratio_ff << 16; sq_res_in = '0;
               sq_bit_in = 64'd1 << 62; sq_run_in = 1'b1;
            end else if (unit_idle) begin
               launched_in = 1'b0; root_in = sq_res_ff;
            end
         end
         ST_TMUL: begin
            if (!launched_ff) begin
               launched_in = 1'b1;
               mul_a_in = 64'(q_item.time_step); mul_b_in = ch64[MUL_B_W-1:0];
               mul_acc_in = '0; mul_cnt_in = 6'(MUL_B_W); mul_run_in = 1'b1;
            end else if (unit_idle) begin
               launched_in = 1'b0; term_in = mul_acc_ff[63:0];
            end
         end
         ST_TDIV: begin
            if (!launched_ff) begin
               if (cfg.domain_length == '0) begin
                  term_in = DMAX;
               end else begin
                  launched_in = 1'b1; div_start = 1'b1;
                  div_num = term_ff; div_den = 64'(cfg.domain_length) << 1;
               end
            end else if (unit_idle) begin
               launched_in = 1'b0; term_in = b64;
            end
         end
         ST_AMUL: begin
            if (!launched_ff) begin
               launched_in = 1'b1;
               mul_a_in = term_ff; mul_b_in = step[MUL_B_W-1:0];
               mul_acc_in = '0; mul_cnt_in = 6'(MUL_B_W); mul_run_in = 1'b1;
            end else if (unit_idle) begin
               launched_in = 1'b0;
               if (root_ff >= ONE_Q) begin
                  a_sum = 65'(old) + 65'(sat_d(mul_res >> 16));
                  a = (a_sum > 65'(DMAX)) ? DMAX : a_sum[63:0];
               end else begin
                  a = ((mul_res >> 16) > old) ? 64'd0 : old - (mul_res >> 16);
               end
               term_in = a;
            end
         end
         ST_GMUL: begin
            if (!launched_ff) begin
               launched_in = 1'b1;
               mul_a_in = old; mul_b_in = MUL_B_W'(ONE_Q + 64'(cfg.max_change));
               mul_acc_in = '0; mul_cnt_in = 6'(MUL_B_W); mul_run_in = 1'b1;
            end else if (unit_idle) begin
               launched_in = 1'b0;
               grow = 64'(sat_d(mul_res >> 16));
               a = term_ff;
               if (a > grow) a = grow;
               if (a > 64'(bound_ff)) a = 64'(bound_ff);
               if (a > amax) a = amax;
               if (a < ONE_Q) a = ONE_Q;
               alpha_in = a[DATA_WIDTH-1:0];
               q_pop = 1'b1; clear = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_alpha_in = a[31:0];
               rsp_mach_in  = mh64[31:0];
               rsp_mean_in  = pmean_ff[31:0];
               rsp_empty_in = 1'b0;
            end
         end
         default: ;
      endcase

      if (clear) begin
         sum_in = '0; cnt_in = '0;
         plow_in = DMAX[DATA_WIDTH-1:0]; phigh_in = '0;
         chigh_in = '0; mhigh_in = '0;
         bound_in = DMAX[DATA_WIDTH-1:0];
      end
      if (alpha_load) begin
         alpha_in = DATA_WIDTH'(alpha_init);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launched_ff  <= 1'b0;
         mul_run_ff   <= 1'b0;
         sq_run_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         plow_ff      <= DMAX[DATA_WIDTH-1:0];
         phigh_ff     <= '0;
         chigh_ff     <= '0;
         mhigh_ff     <= '0;
         bound_ff     <= DMAX[DATA_WIDTH-1:0];
         alpha_ff     <= DATA_WIDTH'(ONE_Q);
      end else begin
         state_ff     <= state_in;
         launched_ff  <= launched_in;
         mul_run_ff   <= mul_run_in;
         sq_run_ff    <= sq_run_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         plow_ff      <= plow_in;
         phigh_ff     <= phigh_in;
         chigh_ff     <= chigh_in;
         mhigh_ff     <= mhigh_in;
         bound_ff     <= bound_in;
         alpha_ff     <= alpha_in;
      end
      pmean_ff   <= pmean_in;
      ratio_ff   <= ratio_in;
      root_ff    <= root_in;
      term_ff    <= term_in;
      mul_a_ff   <= mul_a_in;
      mul_b_ff   <= mul_b_in;
      mul_acc_ff <= mul_acc_in;
      mul_cnt_ff <= mul_cnt_in;
      sq_v_ff    <= sq_v_in;
      sq_res_ff  <= sq_res_in;
      sq_bit_ff  <= sq_bit_in;
      rsp_alpha_ff <= rsp_alpha_in;
      rsp_mach_ff  <= rsp_mach_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_mean_ff, rsp_mach_ff, rsp_alpha_ff};
   assign rsp_tuser  = rsp_empty_ff;
endmodule

FILE: src/pressure_gradient_scale_update_unit.sv
// top level of the pressure gradient scale update block
`timescale 1ns / 1ps
// usage:
// the req_ stream carries one request per cell sample (req_tuser low) or a
// finish request (req_tuser high) that holds the time step. samples update
// the pressure sum, count, extremes, sound speed and mach maxima and the mach
// bound on alpha; a finish computes the new alpha and returns one result on
// the rsp_ stream, then clears the accumulators. samples produce no result.
// csr_ writes are taken whenever csr_we is high; a write to alpha_init also
// loads alpha. they must only be made while no request is in flight.
// a sample with zero mach needs no divider pass; any other sample waits on
// the bit-serial 64-step divider it needs for the bound. a finish runs up to
// three divider passes, four 34-step serial multiplies and a 32-step square
// root, all sharing one sequencer. an empty pass answers straight from idle.
// a two-entry request queue lets requests land while the sequencer works; the
// result sits in an output register, so a stalled receiver holds up only the
// next finish and the requests queued behind it, not the samples ahead of it.
// reset clears the queue, the accumulators, the result and loads default
// register values, with alpha set to 1.0.
module pressure_gradient_scale_update_unit #(
   parameter int DATA_WIDTH  = pgs_pkg::DATA_WIDTH_DEF,
   parameter int COUNT_WIDTH = pgs_pkg::COUNT_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [127:0]                    req_tdata,  // pressure, sound_speed, mach_number, time_step
   input  logic                            req_tuser,  // op
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [95:0]                     rsp_tdata,  // alpha, max_mach, mean_pressure
   output logic                            rsp_tuser,  // empty_pass
   input  logic                            csr_we,
   input  logic [pgs_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [pgs_pkg::FIELD_W-1:0]     csr_wdata
);
   import pgs_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   item_type q_item;
   logic     q_valid, q_pop, alpha_load;

   always_comb begin
      cfg_in     = cfg_ff;
      alpha_load = 1'b0;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_ALPHA_INIT:    alpha_load = 1'b1;
            CSR_DOMAIN_LENGTH: cfg_in.domain_length = csr_wdata;
            CSR_MAX_ALPHA:     cfg_in.max_alpha = csr_wdata;
            CSR_PRESSURE_FAC:  cfg_in.pressure_fac = csr_wdata[FAC_W-1:0];
            CSR_MAX_MACH:      cfg_in.max_mach = csr_wdata;
            CSR_MAX_CHANGE:    cfg_in.max_change = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.domain_length <= 32'd65536;
         cfg_ff.max_alpha     <= 32'd6553600;
         cfg_ff.pressure_fac  <= 17'd3277;
         cfg_ff.max_mach      <= 32'd65536;
         cfg_ff.max_change    <= 32'd6554;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pgs_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   pgs_back #(.DATA_WIDTH(DATA_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .cfg        (cfg_ff),
      .alpha_load (alpha_load),
      .alpha_init (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );
endmodule

FILE: src/pgs_checker.sv
// port-level checks for the pressure gradient scale update block
`timescale 1ns / 1ps
module pgs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic        rsp_tuser
);
   // an empty pass reports zero mean and zero mach
   a_empty_mean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[95:32] == '0)
      else $error("empty pass with non-zero mean or mach");

   // no result straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown after reset");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");
endmodule

bind pressure_gradient_scale_update_unit pgs_checker u_pgs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: test/testbench.sv
// self-checking testbench for the pressure gradient scale update unit
`timescale 1ns / 1ps
module testbench;
   import pgs_pkg::*;

   localparam logic [63:0] DMAX = 64'hFFFF_FFFF;
   localparam int WATCHDOG = 20000;

   typedef struct packed {
      logic        finish;
      logic [31:0] pressure;
      logic [31:0] sound_speed;
      logic [31:0] mach;
      logic [31:0] dt;
   } sample_type;

   typedef struct packed {
      logic [31:0] alpha;
      logic [31:0] max_mach;
      logic [31:0] mean_pressure;
      logic        empty;
   } update_type;

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, req_tuser = 0, rsp_tready = 0, csr_we = 0;
   logic [127:0] req_tdata = '0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [31:0] csr_wdata = '0;
   wire req_tready, rsp_tvalid, rsp_tuser;
   wire [95:0] rsp_tdata;

   pressure_gradient_scale_update_unit u_dut (.*);

   initial forever #5 clock = ~clock;

   // predictor copy of registers and accumulators
   logic [63:0] r_alpha_init, r_length, r_amax, r_fac, r_mmax, r_change;
   logic [63:0] p_sum, p_count, p_low, p_high, c_high, m_high, a_bound, a_val;

   sample_type pending_requests[$];
   update_type expected_updates[$];
   int errors = 0, idle_cycles = 0, gap = 0, stall = 0;
   bit stim_done = 0, hold_off = 0;

   task automatic report(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   function automatic logic [63:0] sat(logic [63:0] v);
      return v > DMAX ? DMAX : v;
   endfunction

   function automatic logic [63:0] mul_sat(logic [63:0] a, logic [63:0] b);
      logic [127:0] pr;
      pr = a * b;
      return pr[127:64] != 0 ? '1 : pr[63:0];
   endfunction

   function automatic logic [63:0] isqrt(logic [63:0] v);
      logic [63:0] res, b;
      res = 0; b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b; res = (res >> 1) + b;
         end else res >>= 1;
         b >>= 2;
      end
      return res;
   endfunction

   task automatic clear_pass();
      p_sum = 0; p_count = 0; p_low = DMAX; p_high = 0;
      c_high = 0; m_high = 0; a_bound = DMAX;
   endtask

   task automatic predict_request(sample_type s);
      logic [63:0] p, c, m, dt, mean, d1, d2, dev, fac, amax, ratio, root, term, a, grow, inc;
      update_type u;
      p = s.pressure; c = s.sound_speed; m = s.mach; dt = s.dt;
      if (!s.finish) begin
         if (p_count < DMAX) begin
            p_count++;
            p_sum = (p_sum > ~64'd0 - p) ? ~64'd0 : p_sum + p;
         end
         if (p < p_low) p_low = p;
         if (p > p_high) p_high = p;
         if (c > c_high) c_high = c;
         if (m > m_high) m_high = m;
         if (m != 0 && sat((r_mmax << 16) / m) < a_bound) a_bound = sat((r_mmax << 16) / m);
         return;
      end
      if (p_count == 0) begin
         u = '{alpha: a_val[31:0], max_mach: m_high[31:0], mean_pressure: 0, empty: 1};
      end else begin
         mean = p_sum / p_count;
         d1 = p_high > mean ? p_high - mean : mean - p_high;
         d2 = p_low > mean ? p_low - mean : mean - p_low;
         dev = d1 > d2 ? d1 : d2;
         fac = r_fac == 0 ? 64'd3277 : r_fac;
         amax = r_amax == 0 ? 64'd6553600 : r_amax;
         if (fac > ONE_Q) fac = ONE_Q;
         mean &= DMAX;
         ratio = dev == 0 ? DMAX : sat((fac * mean) / dev);
         root = isqrt(ratio << 16);
         term = r_length == 0 ? DMAX : sat((dt * c_high) / (64'd2 * r_length));
         if (root >= ONE_Q) begin
            inc = sat(mul_sat(term, root - ONE_Q) >> 16);
            a = sat(a_val + inc);
         end else begin
            inc = mul_sat(term, ONE_Q - root) >> 16;
            a = inc > a_val ? 0 : a_val - inc;
         end
         grow = sat(mul_sat(ONE_Q + r_change, a_val) >> 16);
         if (a > grow) a = grow;
         if (a > a_bound) a = a_bound;
         if (a > amax) a = amax;
         if (a < ONE_Q) a = ONE_Q;
         a_val = a;
         u = '{alpha: a[31:0], max_mach: m_high[31:0], mean_pressure: mean[31:0], empty: 0};
      end
      expected_updates.push_back(u);
      clear_pass();
   endtask

   // driver
   always @(posedge clock) begin
      int nxt_gap;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_request(pending_requests.pop_front());
            nxt_gap = $urandom_range(0, 15) * ($urandom_range(0, 3) != 0);
            gap <= nxt_gap;
            if (nxt_gap == 0 && pending_requests.size() != 0 && !hold_off) begin
               // next request follows with no gap
               req_tuser  <= pending_requests[0].finish;
               req_tdata  <= {pending_requests[0].dt, pending_requests[0].mach,
                              pending_requests[0].sound_speed, pending_requests[0].pressure};
            end else begin
               req_tvalid <= 0;
            end
         end else if (!req_tvalid && pending_requests.size() != 0 && !hold_off) begin
            if (gap != 0) gap <= gap - 1;
            else begin
               req_tvalid <= 1;
               req_tuser  <= pending_requests[0].finish;
               req_tdata  <= {pending_requests[0].dt, pending_requests[0].mach,
                              pending_requests[0].sound_speed, pending_requests[0].pressure};
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      update_type got, exp_u;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64], rsp_tuser};
            if (expected_updates.size() == 0) report("result with none expected");
            else begin
               exp_u = expected_updates.pop_front();
               if (got.alpha != exp_u.alpha)
                  report($sformatf("alpha %h exp %h", got.alpha, exp_u.alpha));
               if (got.max_mach != exp_u.max_mach)
                  report($sformatf("max_mach %h exp %h", got.max_mach, exp_u.max_mach));
               if (got.mean_pressure != exp_u.mean_pressure)
                  report($sformatf("mean %h exp %h", got.mean_pressure, exp_u.mean_pressure));
               if (got.empty != exp_u.empty)
                  report($sformatf("empty_pass %b exp %b", got.empty, exp_u.empty));
            end
            stall <= $urandom_range(0, 15) * ($urandom_range(0, 3) != 0);
            rsp_tready <= 0;
         end else if (stall != 0) begin
            stall <= stall - 1;
            rsp_tready <= 0;
         end else rsp_tready <= 1;
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic write_reg(csr_idx_type idx, logic [31:0] v);
      @(posedge clock);
      csr_we <= 1; csr_addr <= idx; csr_wdata <= v;
      case (idx)
         CSR_ALPHA_INIT:    begin r_alpha_init = v; a_val = v; end
         CSR_DOMAIN_LENGTH: r_length = v;
         CSR_MAX_ALPHA:     r_amax = v;
         CSR_PRESSURE_FAC:  r_fac = v[16:0];
         CSR_MAX_MACH:      r_mmax = v;
         default:           r_change = v;
      endcase
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic drain();
      while (pending_requests.size() != 0 || req_tvalid || expected_updates.size() != 0)
         @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return '1;
         2: return $urandom_range(0, 255) << 16;
         default: return $urandom;
      endcase
   endfunction

   task automatic add(bit fin, logic [31:0] p, c, m, dt);
      pending_requests.push_back('{finish: fin, pressure: p, sound_speed: c, mach: m, dt: dt});
   endtask

   task automatic random_pass(int n, bit wild);
      logic [31:0] base;
      base = $urandom_range(1, 2000) << 16;
      for (int i = 0; i < n; i++)
         if (wild) add(0, rand_word(), rand_word(), rand_word(), rand_word());
         else add(0, base + $urandom_range(0, 65536 * 8), $urandom_range(0, 400) << 16,
                  $urandom_range(0, 3 << 16), $urandom);
      add(1, $urandom, $urandom, $urandom, wild ? rand_word() : $urandom_range(0, 65536 * 4));
   endtask

   initial begin
      r_alpha_init = 65536; r_length = 65536; r_amax = 6553600;
      r_fac = 3277; r_mmax = 65536; r_change = 6554;
      a_val = 65536;
      clear_pass();
      repeat (3) @(posedge clock);
      reset <= 0;
      // directed: empty pass, extremes, zero mach, zero deviation
      add(1, 0, 0, 0, 0);
      add(0, '1, '1, '1, '1);
      add(0, 0, 0, 0, 0);
      add(1, '1, '1, '1, '1);
      add(0, 32'd100 << 16, 32'd340 << 16, 0, 0);
      add(0, 32'd100 << 16, 32'd340 << 16, 0, 0);
      add(1, 0, 0, 0, 32'h0001_0000);
      add(0, 32'd100 << 16, 32'd300 << 16, 32'h0000_8000, 0);
      add(0, 32'd101 << 16, 32'd300 << 16, 32'h0000_0001, 0);
      add(1, 0, 0, 0, 32'h0000_4000);
      add(1, 0, 0, 0, 0);
      drain();
      // hold the sender while a whole pass is queued, then let it go
      hold_off = 1;
      random_pass(4, 0);
      repeat (20) @(posedge clock);
      hold_off = 0;
      drain();
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_reg(CSR_ALPHA_INIT, 32'h0001_0000);
               write_reg(CSR_DOMAIN_LENGTH, 1);
               write_reg(CSR_MAX_ALPHA, 0);
               write_reg(CSR_PRESSURE_FAC, 0);
               write_reg(CSR_MAX_MACH, 0);
               write_reg(CSR_MAX_CHANGE, 0);
            end
            1: begin
               write_reg(CSR_ALPHA_INIT, '1);
               write_reg(CSR_DOMAIN_LENGTH, '1);
               write_reg(CSR_MAX_ALPHA, '1);
               write_reg(CSR_PRESSURE_FAC, 32'h1FFFF);
               write_reg(CSR_MAX_MACH, '1);
               write_reg(CSR_MAX_CHANGE, '1);
            end
            2: begin
               write_reg(CSR_DOMAIN_LENGTH, 0);
               write_reg(CSR_PRESSURE_FAC, 32'h10000);
            end
            default: begin
               write_reg(CSR_ALPHA_INIT, $urandom_range(65536, 65536 * 50));
               write_reg(CSR_DOMAIN_LENGTH, $urandom_range(1, 65536 * 100));
               write_reg(CSR_MAX_ALPHA, $urandom_range(65536, 65536 * 200));
               write_reg(CSR_PRESSURE_FAC, $urandom_range(0, 65536));
               write_reg(CSR_MAX_MACH, $urandom_range(0, 65536 * 4));
               write_reg(CSR_MAX_CHANGE, $urandom_range(0, 65536));
            end
         endcase
         for (int k = 0; k < 230; ) begin
            int n;
            n = $urandom_range(0, 12);
            random_pass(n, $urandom_range(0, 4) == 0);
            k += n + 1;
         end
         drain();
      end
      if (errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule

FILE: files.f
src/pgs_pkg.sv
src/pgs_div.sv
src/pgs_front.sv
src/pgs_back.sv
src/pressure_gradient_scale_update_unit.sv
src/pgs_checker.sv
test/testbench.sv
